@@ rtl/tdag_pkg.sv @@
`default_nettype none

package tdag_pkg;

  // Largest tree height; a larger register value saturates to this.
  localparam int MAX_HEIGHT = 16;
  // Coordinate width, fixed by the value and range fields.
  localparam int VAL_W      = 16;
  // Width of the tree height register.
  localparam int HGT_W      = 5;
  // Configuration bus.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  // Register index of tree_height.
  localparam logic REG_TREE_HEIGHT = 1'b0;

  // Which range the datapath places in the output register.
  typedef enum logic [1:0] {
    SEL_NODE,
    SEL_MID,
    SEL_LEAF,
    SEL_ERR
  } sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    sel_t sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic err;
    logic mid_hit;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/tdag_if.sv @@
`default_nettype none

interface tdag_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdag_pkg::VAL_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdag_out_if;
  logic                         valid;
  logic                         ready;
  logic [tdag_pkg::VAL_W-1:0]   range_low;
  logic [tdag_pkg::VAL_W-1:0]   range_high;
  logic                         is_last;
  logic                         out_of_range;

  modport source (output valid, output range_low, output range_high, output is_last,
                  output out_of_range, input ready);
  modport sink   (input valid, input range_low, input range_high, input is_last,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

@@ rtl/tdag_dpath.sv @@
`default_nettype none

module tdag_dpath (
  input  wire logic                         clk,
  input  wire logic [tdag_pkg::VAL_W-1:0]   in_value,
  input  wire logic [tdag_pkg::HGT_W-1:0]   tree_height,
  input  wire tdag_pkg::cmd_t               cmd,
  output tdag_pkg::status_t                 status,
  output logic [tdag_pkg::VAL_W-1:0]        range_low,
  output logic [tdag_pkg::VAL_W-1:0]        range_high,
  output logic                              is_last,
  output logic                              out_of_range
);
  import tdag_pkg::*;

  logic [VAL_W-1:0] val_r, lo_r, hi_r;
  logic             err_r;
  logic [VAL_W-1:0] out_lo_r, out_hi_r;
  logic             out_last_r, out_err_r;

  logic [HGT_W-1:0] h_eff;
  logic [VAL_W:0]   top;
  logic [VAL_W-1:0] w, mid, q, m0, m1;
  logic [VAL_W-1:0] lo_nxt, hi_nxt;

  // Root bound 2^h - 1, with the height saturated.
  assign h_eff = (tree_height > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : tree_height;
  assign top   = ((VAL_W+1)'(1) << h_eff) - (VAL_W+1)'(1);

  // Current node: width, middle point and middle range.
  assign w   = hi_r - lo_r;
  assign mid = lo_r + (w >> 1);
  assign q   = w >> 2;
  assign m0  = mid - q;
  assign m1  = mid + q + VAL_W'(w[1:0] != 2'b00);

  assign status.done    = (lo_r == hi_r);
  assign status.err     = err_r;
  assign status.mid_hit = (w > VAL_W'(1)) && (val_r >= m0) && (val_r <= m1);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = top[VAL_W-1:0];
    end else if (cmd.step) begin
      if (val_r <= mid) begin
        hi_nxt = mid;
      end else begin
        lo_nxt = mid + VAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.load) begin
      val_r <= in_value;
      err_r <= ({1'b0, in_value} > top);
    end
    if (cmd.emit) begin
      unique case (cmd.sel)
        SEL_NODE: begin
          out_lo_r   <= lo_r;
          out_hi_r   <= hi_r;
          out_last_r <= 1'b0;
          out_err_r  <= 1'b0;
        end
        SEL_MID: begin
          out_lo_r   <= m0;
          out_hi_r   <= m1;
          out_last_r <= 1'b0;
          out_err_r  <= 1'b0;
        end
        SEL_LEAF: begin
          out_lo_r   <= val_r;
          out_hi_r   <= val_r;
          out_last_r <= 1'b1;
          out_err_r  <= 1'b0;
        end
        SEL_ERR: begin
          out_lo_r   <= '0;
          out_hi_r   <= '0;
          out_last_r <= 1'b1;
          out_err_r  <= 1'b1;
        end
        default: begin
          out_lo_r   <= out_lo_r;
          out_hi_r   <= out_hi_r;
          out_last_r <= out_last_r;
          out_err_r  <= out_err_r;
        end
      endcase
    end
  end

  assign range_low    = out_lo_r;
  assign range_high   = out_hi_r;
  assign is_last      = out_last_r;
  assign out_of_range = out_err_r;

endmodule

`default_nettype wire

@@ rtl/tdag_ctrl.sv @@
`default_nettype none

module tdag_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tdag_pkg::status_t  status,
  output tdag_pkg::cmd_t          cmd
);
  import tdag_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_MID
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register may be refilled when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.sel       = SEL_NODE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          priority if (status.err) begin
            cmd.sel   = SEL_ERR;
            state_nxt = ST_IDLE;
          end else if (status.done) begin
            cmd.sel   = SEL_LEAF;
            state_nxt = ST_IDLE;
          end else begin
            cmd.sel = SEL_NODE;
            if (status.mid_hit) begin
              state_nxt = ST_MID;
            end else begin
              cmd.step = 1'b1;
            end
          end
        end
      end
      ST_MID: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = SEL_MID;
          cmd.step      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_NODE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/tdag_path_range_list.sv @@
// Lists the path of covering ranges for one coordinate in a tree-like DAG
// whose root range is [0, 2^h - 1], h being the tree_height register.
// The request channel in_req carries one value; the result channel out_rsp
// returns the node range of every level walked, the middle range of a
// level where the value lies inside it, and finally the leaf [value, value]
// with is_last set. A value beyond the root gives a single result with
// out_of_range and is_last set and both bounds zero.
// A request is taken only while no walk is in progress, but it may be taken
// while the last result of the previous request still waits in the output
// register. After acceptance the controller loads the value and moves to its
// node state, which writes the first result into the single output register;
// then the walk controller emits one range per cycle while the receiver takes
// them. A request gives at most 2h results (one for h = 0), so at most 32.
// When the receiver stalls, the output register holds its result and the
// walk pauses until it is taken. Reset empties the output register, returns
// the controller to idle and sets tree_height to 16. The height is written
// over the APB port, at byte address 0; the user must write it only while
// the block is idle, and the block itself does not enforce this.
`default_nettype none

module tdag_path_range_list (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tdag_in_if.sink                                in_req,
  tdag_out_if.source                             out_rsp,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tdag_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [tdag_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tdag_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import tdag_pkg::*;

  logic [HGT_W-1:0] tree_height_r;
  logic             reg_sel;
  cmd_t             cmd;
  status_t          status;

  // Register block: one register, selected by the word address bit.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TREE_HEIGHT);
  assign prdata  = reg_sel ? CFG_DATA_W'(tree_height_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_height_r <= HGT_W'(16);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tree_height_r <= pwdata[HGT_W-1:0];
    end
  end

  // The controller sequences the walk; the datapath keeps the node bounds
  // and the output register.
  tdag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tdag_dpath u_dpath (
    .clk          (clk),
    .in_value     (in_req.value),
    .tree_height  (tree_height_r),
    .cmd          (cmd),
    .status       (status),
    .range_low    (out_rsp.range_low),
    .range_high   (out_rsp.range_high),
    .is_last      (out_rsp.is_last),
    .out_of_range (out_rsp.out_of_range)
  );

  // Once a request is taken, no further request is taken in the next cycle.
  a_one_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while a walk was starting");

  // An error result carries zero bounds and closes the list.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.out_of_range) |->
      (out_rsp.is_last && out_rsp.range_low == '0 && out_rsp.range_high == '0))
    else $error("malformed out-of-range result");

  // The closing result of a normal walk is a single point.
  a_leaf_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.is_last && !out_rsp.out_of_range) |->
      (out_rsp.range_low == out_rsp.range_high))
    else $error("leaf result is not a single point");

  // Every range emitted is ordered.
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.range_low <= out_rsp.range_high))
    else $error("range bounds out of order");

endmodule

`default_nettype wire

@@ tb/sv/tdag_path_checker.sv @@
`timescale 1ns / 1ps

module tdag_path_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tdag_in_if                                   in_mon,
  tdag_out_if                                  out_mon,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic                            pready,
  input  wire logic [tdag_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tdag_pkg::CFG_DATA_W-1:0] pwdata,
  input  wire logic [tdag_pkg::CFG_DATA_W-1:0] prdata,
  output int unsigned                          fail_count,
  output int unsigned                          ranges_pending,
  output int unsigned                          requests_seen,
  output int unsigned                          ranges_checked
);
  import tdag_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] high;
    logic             last;
    logic             beyond;
  } range_t;

  range_t           path_q[$];
  range_t           oldest;
  logic [HGT_W-1:0] height_reg;

  initial begin
    fail_count     = 0;
    ranges_pending = 0;
    requests_seen  = 0;
    ranges_checked = 0;
    height_reg     = 5'd16;
  end

  function automatic void push_range(input int unsigned lo, input int unsigned hi,
                                     input logic last, input logic beyond);
    range_t r;
    r.low    = lo[VAL_W-1:0];
    r.high   = hi[VAL_W-1:0];
    r.last   = last;
    r.beyond = beyond;
    path_q.insert(path_q.size(), r);
  endfunction

  // Walks the implicit tree from the root down to the leaf of val.
  function automatic void queue_path(input logic [VAL_W-1:0] val, input logic [HGT_W-1:0] hgt);
    int unsigned eff, top, lo, hi, w, mid, q, m0, m1, lvl;
    eff = (hgt > MAX_HEIGHT) ? MAX_HEIGHT : hgt;
    top = (32'd1 << eff) - 32'd1;
    if (val > top) begin
      push_range(0, 0, 1'b1, 1'b1);
      return;
    end
    lo  = 0;
    hi  = top;
    lvl = 0;
    while (lvl <= MAX_HEIGHT && lo != hi) begin
      w   = hi - lo;
      mid = lo + w / 2;
      q   = w / 4;
      m0  = mid - q;
      m1  = mid + q + (((w % 4) > 0) ? 1 : 0);
      push_range(lo, hi, 1'b0, 1'b0);
      if (w > 1 && val >= m0 && val <= m1) begin
        push_range(m0, m1, 1'b0, 1'b0);
      end
      if (val <= mid) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
      lvl++;
    end
    push_range(val, val, 1'b1, 1'b0);
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      height_reg = 5'd16;
      path_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (path_q.size() == 0) begin
          $error("unexpected range [%0d, %0d] with nothing outstanding",
                 out_mon.range_low, out_mon.range_high);
          fail_count++;
        end else begin
          oldest = path_q.pop_front();
          compare_field("range_low", oldest.low, out_mon.range_low);
          compare_field("range_high", oldest.high, out_mon.range_high);
          compare_field("is_last", oldest.last, out_mon.is_last);
          compare_field("out_of_range", oldest.beyond, out_mon.out_of_range);
          ranges_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        queue_path(in_mon.value, height_reg);
        requests_seen++;
      end
      if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_TREE_HEIGHT) begin
        if (pwrite) begin
          height_reg = pwdata[HGT_W-1:0];
        end else begin
          compare_field("tree_height", height_reg, prdata[HGT_W-1:0]);
        end
      end
    end
    ranges_pending = path_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tdag_pkg::*;

  // Generous bound: even 550 requests of 32 ranges each, every range held
  // off by the longest random stall, stay well below this.
  localparam int unsigned CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned RANDOM_PER_HEIGHT = 38;
  localparam int unsigned LONG_HOLD_CYCLES  = 300;
  // Only index 0 is decoded; index 1 is an unused slot whose writes must
  // leave the height untouched.
  localparam logic                  SPARE_INDEX = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] HEIGHT_ADDR = {REG_TREE_HEIGHT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR  = {SPARE_INDEX, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned ranges_pending;
  int unsigned requests_seen;
  int unsigned ranges_checked;
  int unsigned cycle_count = 0;

  // Idling controls for the request side and the result side. A quiet
  // side never inserts gaps; the long hold is a one-off request to the
  // result side.
  bit src_quiet     = 1'b0;
  bit sink_quiet    = 1'b0;
  bit long_hold_req = 1'b0;

  tdag_in_if  in_req();
  tdag_out_if out_rsp();

  tdag_path_range_list i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tdag_path_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_req),
    .out_mon        (out_rsp),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .fail_count     (fail_count),
    .ranges_pending (ranges_pending),
    .requests_seen  (requests_seen),
    .ranges_checked (ranges_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost range ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side. For every range it draws a random hold-off, unless it is
  // quiet. When the long hold is requested it keeps ready low
  // for a long stretch, counted here, so that the walk backs up and the
  // block refuses further requests while the sender keeps offering them.
  initial begin
    int unsigned stall;
    out_rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 6);
      if (long_hold_req) begin
        stall         = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
    end
  end

  // Offers one request and returns at the edge that accepts it. Valid is
  // left high afterwards, so that a back-to-back request simply replaces
  // the value at the next falling edge instead of dropping valid and
  // raising it again in the same step.
  task automatic send_value(input logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.value <= v;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Withdraws the request channel and waits until every expected range
  // has been returned. Since each request yields at least one range, an
  // empty expectation store means the walk has finished; the spare wait
  // after it covers the controller going back to idle.
  task automatic drain();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (ranges_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One APB transfer: setup phase, then access phase until pready.
  task automatic cfg_access(input logic [CFG_ADDR_W-1:0] addr, input logic wr,
                            input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The height is only changed once the block is idle; the read back is
  // checked by the checker against its own copy of the register.
  task automatic set_height(input int unsigned h);
    drain();
    cfg_access(HEIGHT_ADDR, 1'b1, h);
    cfg_access(HEIGHT_ADDR, 1'b0, '0);
  endtask

  initial begin
    logic [VAL_W-1:0] vals[$];
    int unsigned      heights[$];
    int unsigned      eff;
    int unsigned      top;
    int unsigned      r;
    logic [VAL_W-1:0] v;

    rst_n        = 1'b0;
    in_req.valid = 1'b0;
    in_req.value = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The reset height must read back as 16.
    cfg_access(HEIGHT_ADDR, 1'b0, '0);

    // Directed part, full height: both ends of the coordinate space, the
    // values either side of the root midpoint and alternating bit patterns,
    // which fall inside middle ranges on many levels.
    vals = '{16'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'd1, 16'h3FFF};
    foreach (vals[i]) send_value(vals[i]);

    // Zero height: only value 0 lies in the root; the rest are beyond it.
    set_height(0);
    vals = '{16'd0, 16'd1, 16'hFFFF};
    foreach (vals[i]) send_value(vals[i]);

    // Height one: a two-wide root with no middle range; 2 is beyond it.
    set_height(1);
    vals = '{16'd0, 16'd1, 16'd2};
    foreach (vals[i]) send_value(vals[i]);

    // Height two: the smallest root that has a middle range.
    set_height(2);
    vals = '{16'd1, 16'd2, 16'd4};
    foreach (vals[i]) send_value(vals[i]);

    // Heights above the maximum saturate to it.
    set_height(31);
    send_value(16'hFFFF);
    send_value(16'd0);
    set_height(17);
    send_value(16'd12345);

    // A write to the unused register slot must leave the height alone.
    drain();
    cfg_access(SPARE_ADDR, 1'b1, 32'd3);
    cfg_access(HEIGHT_ADDR, 1'b0, '0);
    send_value(16'd40000);

    // Height fifteen: the top of the root is reachable, one above it is not.
    set_height(15);
    send_value(16'h7FFF);
    send_value(16'h8000);

    // Random part. Each phase uses one height, with the extremes among
    // them. Most values lie inside the root so that those requests walk the
    // full path; a few are the root's top or one above it, and a few are
    // drawn over the whole 16 bits.
    heights = '{16, 4, 0, 16, 1, 2, 31, 8, 12, 3, 17, 15, 16};
    foreach (heights[ph]) begin
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      // In this phase the sender offers back to back while the receiver
      // holds off, so the block fills up and stalls its request channel.
      if (ph == 3) begin
        src_quiet = 1'b1;
      end
      set_height(heights[ph]);
      eff = (heights[ph] > MAX_HEIGHT) ? MAX_HEIGHT : heights[ph];
      top = (32'd1 << eff) - 32'd1;
      for (int unsigned n = 0; n < RANDOM_PER_HEIGHT; n++) begin
        if (ph == 3 && n == 5) begin
          long_hold_req = 1'b1;
        end
        // Here the sender stops until every outstanding range has come.
        if (ph == 6 && n == RANDOM_PER_HEIGHT / 2) begin
          drain();
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
          v = VAL_W'($urandom_range(0, 65535));
        end else if (r == 1) begin
          v = VAL_W'((top < 65535 && $urandom_range(0, 1) == 1) ? top + 1 : top);
        end else begin
          v = VAL_W'($urandom_range(0, top));
        end
        send_value(v);
      end
    end

    // Let every outstanding range arrive, then give any stray result time
    // to show itself.
    drain();
    repeat (40) @(posedge clk);

    $display("Checked %0d ranges from %0d requests over heights 0 to 31,",
             ranges_checked, requests_seen);
    $display("with values beyond the root, a long result stall and idle-only writes.");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tdag_pkg.sv
rtl/tdag_if.sv
rtl/tdag_dpath.sv
rtl/tdag_ctrl.sv
rtl/tdag_path_range_list.sv
tb/sv/tdag_path_checker.sv
tb/sv/tb.sv
